>>> hdl/stfb_pkg.sv
// Package for the sensor table frame builder.
// Table geometry, entry layout, operation, status and register codes.
// No dependencies; used by sensor_table_frame_builder_top.
package stfb_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // bytes per entry in a frame: id, type, four value bytes
   localparam int ENTRY_BYTES = 6;
   localparam logic [2:0] LAST_ENTRY_BYTE = 3'(ENTRY_BYTES - 1);

   // input operations
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_SEND   = 1'b1;

   // result kinds
   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // update status codes
   localparam logic [1:0] ST_UPDATED  = 2'd0;
   localparam logic [1:0] ST_APPENDED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_BINARY_ENABLE = 3'd0;
   localparam logic [2:0] CSR_START_BYTE    = 3'd1;
   localparam logic [2:0] CSR_END_BYTE      = 3'd2;
   localparam logic [2:0] CSR_SHORT_TYPE_A  = 3'd3;
   localparam logic [2:0] CSR_SHORT_TYPE_B  = 3'd4;

   // one table entry as stored in memory
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  vtype;
      logic [31:0] value;
   } table_entry_type;

   // byte of an entry in frame order
   function automatic logic [7:0] entry_byte(input table_entry_type e, input logic [2:0] sel);
      logic [7:0] b;
      b = 8'h00;
      unique case (sel)
         3'd0:    b = e.id;
         3'd1:    b = e.vtype;
         3'd2:    b = e.value[7:0];
         3'd3:    b = e.value[15:8];
         3'd4:    b = e.value[23:16];
         3'd5:    b = e.value[31:24];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> hdl/sensor_table_frame_builder_top.sv
// Sensor table frame builder: sensor table in a one-port-read memory,
// update search sequencer and binary frame emitter.
// Depends on stfb_pkg.
//
// Usage:
//   req_* channel carries one word per item: op 0 updates the entry for
//   req_sensor_id (found or appended), op 1 sends the table as a frame.
//   rsp_* channel returns results: one status word per update, or one frame
//   byte per word for a send (start, count, 6 bytes per entry, XOR checksum,
//   end), with rsp_last on the final word. A send with binary_enable clear
//   returns nothing.
//   csr_* channel writes the five registers; csr_ready is always high.
//   Writes are expected only while the block is idle.
// Timing:
//   One item at a time. An update scans the table entry by entry (read,
//   compare) until the id matches or the count is reached, then writes the
//   entry (or reports a full table) and returns its status. A send streams
//   6*count+4 bytes, one per cycle while rsp_stall does not hold the output;
//   each entry read is issued while the previous entry's last byte goes out.
// Reset: clears the entry count and registers to their defaults; the table
//   memory itself is not cleared, entries are written when appended.
// Stall: rsp_stall holds the output register; the sequencer waits, and
//   req_stall stays high until the current item is finished.
module sensor_table_frame_builder_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_sensor_id,
   input  logic [7:0]  req_value_type,
   input  logic [31:0] req_value_word,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_frame_byte,
   output logic [1:0]  rsp_update_status,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import stfb_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_U_READ  = 9'b000000010,
      S_U_CHECK = 9'b000000100,
      S_U_WRITE = 9'b000001000,
      S_HEAD    = 9'b000010000,
      S_COUNT   = 9'b000100000,
      S_BYTES   = 9'b001000000,
      S_SUM     = 9'b010000000,
      S_END     = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [2:0]          bsel_ff, bsel_in;
   logic                hit_ff, hit_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          id_ff, id_in;
   logic [7:0]          vtype_ff, vtype_in;
   logic [31:0]         word_ff, word_in;

   logic                binary_enable_ff, binary_enable_in;
   logic [7:0]          start_byte_ff, start_byte_in;
   logic [7:0]          end_byte_ff, end_byte_in;
   logic [7:0]          short_a_ff, short_a_in;
   logic [7:0]          short_b_ff, short_b_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // table memory, one write and one registered read per cycle
   table_entry_type     table_mem [TABLE_DEPTH];
   table_entry_type     rd_data_ff;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   table_entry_type     mem_wdata;

   logic                out_free, emit, accept, is_short;
   logic [7:0]          emit_byte;
   logic [CNT_W-1:0]    idx_next_cnt;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      binary_enable_in = binary_enable_ff;
      start_byte_in    = start_byte_ff;
      end_byte_in      = end_byte_ff;
      short_a_in       = short_a_ff;
      short_b_in       = short_b_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BINARY_ENABLE: binary_enable_in = csr_data[0];
            CSR_START_BYTE:    start_byte_in    = csr_data;
            CSR_END_BYTE:      end_byte_in      = csr_data;
            CSR_SHORT_TYPE_A:  short_a_in       = csr_data;
            CSR_SHORT_TYPE_B:  short_b_in       = csr_data;
            default:           ;
         endcase
      end
   end

   // handshake helpers
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
   assign is_short     = (vtype_ff == short_a_ff) || (vtype_ff == short_b_ff);
   assign emit_byte    = entry_byte(rd_data_ff, bsel_ff);

   // capture of the accepted item
   assign id_in    = accept ? req_sensor_id  : id_ff;
   assign vtype_in = accept ? req_value_type : vtype_ff;
   assign word_in  = accept ? req_value_word : word_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      bsel_in       = bsel_ff;
      hit_in        = hit_ff;
      sum_in        = sum_ff;
      emit          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_UPDATE) begin
                  idx_in = '0;
                  hit_in = 1'b0;
                  state_in = (count_ff == '0) ? S_U_WRITE : S_U_READ;
               end else if (binary_enable_ff) begin
                  state_in = S_HEAD;
               end
            end
         end
         S_U_READ: begin
            mem_re   = 1'b1;
            state_in = S_U_CHECK;
         end
         S_U_CHECK: begin
            if (rd_data_ff.id == id_ff) begin
               hit_in   = 1'b1;
               state_in = S_U_WRITE;
            end else if (idx_next_cnt == count_ff) begin
               state_in = S_U_WRITE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_U_READ;
            end
         end
         S_U_WRITE: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_byte_in   = 8'h00;
               rsp_last_in   = 1'b1;
               mem_wdata.id    = id_ff;
               mem_wdata.vtype = vtype_ff;
               if (hit_ff) begin
                  // existing entry, short types keep the upper value bytes
                  mem_we          = 1'b1;
                  mem_waddr       = idx_ff;
                  mem_wdata.value = is_short ? {rd_data_ff.value[31:8], word_ff[7:0]}
                                             : word_ff;
                  rsp_status_in   = ST_UPDATED;
               end else if (count_ff < DEPTH_CNT) begin
                  // fresh entry, short types start with zero upper bytes
                  mem_we          = 1'b1;
                  mem_waddr       = count_ff[IDX_W-1:0];
                  mem_wdata.value = is_short ? {24'h000000, word_ff[7:0]} : word_ff;
                  count_in        = count_ff + CNT_W'(1);
                  rsp_status_in   = ST_APPENDED;
               end else begin
                  rsp_status_in   = ST_FULL;
               end
               state_in = S_IDLE;
            end
         end
         S_HEAD: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_kind_in   = KIND_FRAME;
               rsp_byte_in   = start_byte_ff;
               rsp_status_in = ST_UPDATED;
               rsp_last_in   = 1'b0;
               state_in      = S_COUNT;
            end
         end
         S_COUNT: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = 8'(count_ff);
               sum_in      = 8'(count_ff);
               idx_in      = '0;
               bsel_in     = 3'd0;
               if (count_ff == '0) begin
                  state_in = S_SUM;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  state_in  = S_BYTES;
               end
            end
         end
         S_BYTES: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = emit_byte;
               sum_in      = sum_ff ^ emit_byte;
               if (bsel_ff == LAST_ENTRY_BYTE) begin
                  bsel_in = 3'd0;
                  if (idx_next_cnt < count_ff) begin
                     // fetch next entry as this one's last byte leaves
                     idx_in    = idx_ff + IDX_W'(1);
                     mem_re    = 1'b1;
                     mem_raddr = idx_ff + IDX_W'(1);
                  end else begin
                     state_in = S_SUM;
                  end
               end else begin
                  bsel_in = bsel_ff + 3'd1;
               end
            end
         end
         S_SUM: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = sum_ff;
               state_in    = S_END;
            end
         end
         S_END: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = end_byte_ff;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         binary_enable_ff <= 1'b0;
         start_byte_ff    <= 8'h02;
         end_byte_ff      <= 8'h03;
         short_a_ff       <= 8'h00;
         short_b_ff       <= 8'h01;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
         binary_enable_ff <= binary_enable_in;
         start_byte_ff    <= start_byte_in;
         end_byte_ff      <= end_byte_in;
         short_a_ff       <= short_a_in;
         short_b_ff       <= short_b_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      bsel_ff  <= bsel_in;
      hit_ff   <= hit_in;
      sum_ff   <= sum_in;
      id_ff    <= id_in;
      vtype_ff <= vtype_in;
      word_ff  <= word_in;
      if (emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_frame_byte    = rsp_byte_ff;
   assign rsp_update_status = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef ASSERT_OFF
   // entry count never runs past the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds table depth");

   // the count only moves together with an appended status word
   a_count_append: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (rsp_valid && rsp_kind == KIND_STATUS && rsp_update_status == ST_APPENDED))
      else $error("entry count changed without an append");

   // frame bytes are only read from entries below the count
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTES) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("frame read beyond stored entries");

   // a status word is always the only result of its item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STATUS) |-> rsp_last)
      else $error("status word without last");
`endif

endmodule
